>>> sv/mids_pkg.sv
// ----------------------------------------------------------------------------
// mids_pkg
// Shared types, register indexes and the per-input debounce update for the
// multiplexed input debounce scanner.
// ----------------------------------------------------------------------------
package mids_pkg;

    localparam int CFG_W      = 8;   // widest config register
    localparam int CFG_IDX_W  = 2;
    localparam int DWELL_W    = 4;
    localparam int NIB_W      = 4;
    localparam int STATES_W   = 32;
    localparam int OUT_SEL_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_NEEDED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TIME   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP      = 2'd2;

    localparam logic [NIB_W-1:0] RST_SAMPLES_NEEDED = 4'd3;
    localparam logic [7:0]       RST_LOCKOUT_TIME   = 8'd50;
    localparam logic [7:0]       RST_TICK_STEP      = 8'd10;

    // Configuration as seen by the update logic
    typedef struct packed {
        logic [NIB_W-1:0] samples_needed;
        logic [7:0]       lockout_time;
        logic [7:0]       tick_step;
    } t_cfg;

    // Stored state of one input: level, run counters (hi nibble counts
    // level 0, lo nibble counts level 1) and lockout timer
    typedef struct packed {
        logic       level;
        logic [7:0] cnt;
        logic [7:0] tmr;
    } t_unit;

    function automatic t_unit debounce_unit(input t_unit st, input logic s,
                                            input t_cfg cfg);
        t_unit            nx;
        logic [NIB_W-1:0] nib;
        nx  = st;
        nib = s ? st.cnt[3:0] : st.cnt[7:4];
        if (st.tmr != 8'd0) begin
            nx.tmr = (st.tmr > cfg.tick_step) ? st.tmr - cfg.tick_step : 8'd0;
        end else begin
            // clear the counter of the opposite level
            if (s) begin
                nx.cnt[7:4] = 4'd0;
            end else begin
                nx.cnt[3:0] = 4'd0;
            end
            if (s != st.level) begin
                if (nib < cfg.samples_needed) begin
                    nib = nib + 4'd1;
                    if (s) begin
                        nx.cnt[3:0] = nib;
                    end else begin
                        nx.cnt[7:4] = nib;
                    end
                end
                if (nib >= cfg.samples_needed) begin
                    nx.level = s;
                    nx.tmr   = cfg.lockout_time;
                end
            end
        end
        return nx;
    endfunction

endpackage

>>> sv/muxed_input_debounce_scanner.sv
// ----------------------------------------------------------------------------
// muxed_input_debounce_scanner
// Scans MUX_UNITS mux units over 2**SELECT_BITS selector groups and debounces
// every input with run counters and a post-commit lockout timer.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                | payload
//  ----------+--------------------------+----------------------------------
//  sample in | i_valid / o_ready        | i_sampled_levels
//  result    | o_valid / i_ready        | o_next_selector, o_debounced_states,
//            |                          | o_any_changed
//  config    | i_cfg_we (no wait)       | i_cfg_idx, i_cfg_data
//
//  Cycles: one request per clock unless stalled; result registered in the
//  cycle after acceptance; the rate is set by the RAM row read-modify-write.
//  Reset: per-row valid flops clear at once; no clearing pass, an unwritten
//  row reads as zero.
//  Stalls: a single output register; a new request is taken whenever the
//  output is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module muxed_input_debounce_scanner
    import mids_pkg::*;
#(
    parameter int MUX_UNITS   = 4,
    parameter int SELECT_BITS = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // sample requests
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [MUX_UNITS-1:0]      i_sampled_levels,
    // results
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [OUT_SEL_W-1:0]      o_next_selector,
    output logic [STATES_W-1:0]       o_debounced_states,
    output logic                      o_any_changed,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    localparam int GROUPS     = 1 << SELECT_BITS;
    localparam int SEL_W      = (SELECT_BITS > 0) ? SELECT_BITS : 1;
    localparam int NUM_INPUTS = MUX_UNITS * GROUPS;
    localparam int ROW_W      = MUX_UNITS * $bits(t_unit);

    // ---------------- configuration registers ----------------
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.samples_needed <= RST_SAMPLES_NEEDED;
            r_cfg.lockout_time   <= RST_LOCKOUT_TIME;
            r_cfg.tick_step      <= RST_TICK_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SAMPLES_NEEDED: r_cfg.samples_needed <= i_cfg_data[NIB_W-1:0];
                REG_LOCKOUT_TIME:   r_cfg.lockout_time   <= i_cfg_data;
                REG_TICK_STEP:      r_cfg.tick_step      <= i_cfg_data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic r_out_valid;
    logic accept;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // ---------------- group selector and dwell ----------------
    logic [SEL_W-1:0]   r_sel, n_sel, sel_inc;
    logic [DWELL_W-1:0] r_dwell, n_dwell, dwell_inc;
    logic               adv;

    assign dwell_inc = r_dwell + DWELL_W'(1);
    assign adv       = (dwell_inc >= r_cfg.samples_needed) || (dwell_inc == '0);
    // with one group the selector stays at zero
    assign sel_inc   = (GROUPS == 1) ? '0 : r_sel + SEL_W'(1);

    always_comb begin
        n_sel   = r_sel;
        n_dwell = r_dwell;
        if (accept) begin
            n_sel   = adv ? sel_inc : r_sel;
            n_dwell = adv ? '0 : dwell_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= '0;
            r_dwell <= '0;
        end else begin
            r_sel   <= n_sel;
            r_dwell <= n_dwell;
        end
    end

    // ---------------- row RAM with forwarding ----------------
    // The RAM is always addressed with the group of the next tick, so the
    // current row sits in the read register when its sample arrives. When
    // the same row is written and read at one edge, the written row is
    // forwarded instead.
    logic [ROW_W-1:0]      rd_data;
    t_unit [MUX_UNITS-1:0] cur_row, upd_row, r_fwd_row;
    logic [GROUPS-1:0]     r_row_vld;
    logic                  r_rd_vld, r_fwd;
    logic                  upd_changed;

    mids_row_mem #(
        .DEPTH (GROUPS),
        .AW    (SEL_W),
        .WIDTH (ROW_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_sel),
        .i_wdata (upd_row),
        .i_raddr (n_sel),
        .o_rdata (rd_data)
    );

    always_comb begin
        if (r_fwd) begin
            cur_row = r_fwd_row;
        end else if (r_rd_vld) begin
            cur_row = rd_data;
        end else begin
            cur_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            r_rd_vld <= r_row_vld[n_sel];
            r_fwd    <= accept && (n_sel == r_sel);
            if (accept) begin
                r_row_vld[r_sel] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_row <= upd_row;
    end

    mids_update #(
        .MUX_UNITS (MUX_UNITS)
    ) u_upd (
        .i_cfg         (r_cfg),
        .i_row         (cur_row),
        .i_samples     (i_sampled_levels),
        .o_row         (upd_row),
        .o_any_changed (upd_changed)
    );

    // ---------------- debounced state image ----------------
    // Flop copy of the first 32 input levels; only the scanned group moves.
    logic [STATES_W-1:0] r_states, n_states;

    for (genvar b = 0; b < STATES_W; b++) begin : g_state
        if (b < NUM_INPUTS) begin : g_used
            localparam int GB = b / MUX_UNITS;
            localparam int UB = b % MUX_UNITS;
            assign n_states[b] = (accept && (r_sel == SEL_W'(GB)))
                               ? upd_row[UB].level : r_states[b];
        end else begin : g_none
            assign n_states[b] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_states <= '0;
        end else begin
            r_states <= n_states;
        end
    end

    // ---------------- output register ----------------
    logic [SEL_W+OUT_SEL_W-1:0] sel_ext;
    logic [OUT_SEL_W-1:0]       r_out_sel;
    logic [STATES_W-1:0]        r_out_states;
    logic                       r_out_chg;

    assign sel_ext = {{OUT_SEL_W{1'b0}}, n_sel};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_out_states <= '0;
            r_out_sel    <= '0;
            r_out_chg    <= 1'b0;
        end else if (accept) begin
            r_out_valid  <= 1'b1;
            r_out_states <= n_states;
            r_out_sel    <= sel_ext[OUT_SEL_W-1:0];
            r_out_chg    <= upd_changed;
        end else if (i_ready) begin
            r_out_valid  <= 1'b0;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_next_selector    = r_out_sel;
    assign o_debounced_states = r_out_states;
    assign o_any_changed      = r_out_chg;

endmodule

>>> sv/mids_row_mem.sv
// ----------------------------------------------------------------------------
// mids_row_mem
// One-write, one-read synchronous RAM holding one row per selector group.
// ----------------------------------------------------------------------------
module mids_row_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int WIDTH = 68
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/mids_update.sv
// ----------------------------------------------------------------------------
// mids_update
// Debounce update of one group row: all mux units in parallel.
// ----------------------------------------------------------------------------
module mids_update
    import mids_pkg::*;
#(
    parameter int MUX_UNITS = 4
) (
    input  t_cfg                        i_cfg,
    input  t_unit [MUX_UNITS-1:0]       i_row,
    input  logic  [MUX_UNITS-1:0]       i_samples,
    output t_unit [MUX_UNITS-1:0]       o_row,
    output logic                        o_any_changed
);

    logic [MUX_UNITS-1:0] chg;

    always_comb begin
        for (int u = 0; u < MUX_UNITS; u++) begin
            o_row[u] = debounce_unit(i_row[u], i_samples[u], i_cfg);
            chg[u]   = o_row[u].level != i_row[u].level;
        end
    end

    assign o_any_changed = |chg;

endmodule

>>> sv/mids_chk.sv
// ----------------------------------------------------------------------------
// mids_chk
// Port-level checks for the debounce scanner, bound to the top level.
// ----------------------------------------------------------------------------
module mids_chk
    import mids_pkg::*;
#(
    parameter int MUX_UNITS = 4
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic [MUX_UNITS-1:0] i_sampled_levels,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [OUT_SEL_W-1:0] o_next_selector,
    input logic [STATES_W-1:0]  o_debounced_states,
    input logic                 o_any_changed
);

    // a waiting request keeps valid and its payload
    a_req_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_ready) |=> (i_valid && $stable(i_sampled_levels)))
        else $error("waiting request dropped or changed");

    // every accepted request yields a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> o_valid)
        else $error("accepted request produced no result");

    // a stalled result keeps its payload
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_debounced_states)
                                   && $stable(o_next_selector)
                                   && $stable(o_any_changed)))
        else $error("stalled result changed");

    // levels only move on a request that reports a change
    a_no_change_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_valid && o_ready) && !o_any_changed)
            |-> (o_debounced_states == $past(o_debounced_states)))
        else $error("levels moved without a reported change");

    // levels never move without a request
    a_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_valid && o_ready) |=> $stable(o_debounced_states))
        else $error("levels moved without a request");

endmodule

bind muxed_input_debounce_scanner mids_chk #(
    .MUX_UNITS (MUX_UNITS)
) u_mids_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_ready            (o_ready),
    .i_sampled_levels   (i_sampled_levels),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_next_selector    (o_next_selector),
    .o_debounced_states (o_debounced_states),
    .o_any_changed      (o_any_changed)
);
